// File: hdl/mdsc_pkg.sv
// shared types, constants, helpers and microcode program for the magnetometer calibration core
package mdsc_pkg;

	localparam int STEP_W = 5;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_FIN = 5'd24;

	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_DECODE    = 2'd0;
	localparam cmd_t CMD_CALIBRATE = 2'd1;
	localparam cmd_t CMD_RESET     = 2'd2;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_STEP_GAIN        = 2'd0;
	localparam reg_idx_t REG_START_RADIUS     = 2'd1;
	localparam reg_idx_t REG_DIVERGENCE_LIMIT = 2'd2;

	localparam logic [31:0] STEP_GAIN_RST        = 32'd0;
	localparam logic [30:0] START_RADIUS_RST     = 31'd655360;
	localparam logic [62:0] DIVERGENCE_LIMIT_RST = 63'h4000_0000_0000_0000;

	localparam logic [33:0] DELTA_CAP = 34'h2_0000_0000;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_DEC,
		OP_MAG,
		OP_FCALC,
		OP_SCALC,
		OP_NUDGE,
		OP_FIN
	} op_t;

	typedef enum logic [2:0] {
		A_MAG,
		A_FLO,
		A_FHI,
		A_SLO,
		A_SHI
	} asel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD,
		ACC_ADD_HI
	} acc_op_t;

	typedef struct packed {
		op_t         op;
		asel_t       a_sel;
		logic        b_gain;
		logic [1:0]  m_idx;
		logic [1:0]  n_idx;
		logic        mul_en;
		acc_op_t     acc;
		logic        jump;
		step_t       target;
	} ucode_t;

	typedef struct packed {
		logic   go;
		logic   start;
		ucode_t uc;
	} ctrl_t;

	typedef struct packed {
		logic signed [31:0] corrected_x;
		logic signed [31:0] corrected_y;
		logic signed [31:0] corrected_z;
		logic signed [63:0] fit_error;
		logic               data_nonzero;
		logic               calibration_was_reset;
	} result_t;

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		if (v > 36'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end else if (v < -36'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return $signed(v[31:0]);
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		logic [31:0] u;
		u = $unsigned(v);
		return u[31] ? (~u + 32'd1) : u;
	endfunction

	function automatic ucode_t uw(input op_t op, input asel_t a_sel, input logic b_gain,
			input logic [1:0] m_idx, input logic [1:0] n_idx, input logic mul_en,
			input acc_op_t acc, input logic jump, input step_t target);
		ucode_t w;
		w.op     = op;
		w.a_sel  = a_sel;
		w.b_gain = b_gain;
		w.m_idx  = m_idx;
		w.n_idx  = n_idx;
		w.mul_en = mul_en;
		w.acc    = acc;
		w.jump   = jump;
		w.target = target;
		return w;
	endfunction

	// control program: decode, magnitudes, squares, error, step size, four nudges, finish
	function automatic ucode_t ucode(input step_t s);
		ucode_t w;
		unique case (s)
			5'd0:  w = uw(OP_DEC,    A_MAG, 1'b0, 2'd0, 2'd0, 1'b0, ACC_HOLD,   1'b0, '0);
			5'd1:  w = uw(OP_MAG,    A_MAG, 1'b0, 2'd0, 2'd0, 1'b0, ACC_HOLD,   1'b1, STEP_FIN);
			5'd2:  w = uw(OP_NONE,   A_MAG, 1'b0, 2'd0, 2'd0, 1'b1, ACC_HOLD,   1'b0, '0);
			5'd3:  w = uw(OP_NONE,   A_MAG, 1'b0, 2'd1, 2'd0, 1'b1, ACC_LOAD,   1'b0, '0);
			5'd4:  w = uw(OP_NONE,   A_MAG, 1'b0, 2'd2, 2'd0, 1'b1, ACC_ADD,    1'b0, '0);
			5'd5:  w = uw(OP_NONE,   A_MAG, 1'b0, 2'd3, 2'd0, 1'b1, ACC_ADD,    1'b0, '0);
			5'd6:  w = uw(OP_FCALC,  A_MAG, 1'b0, 2'd0, 2'd0, 1'b0, ACC_HOLD,   1'b0, '0);
			5'd7:  w = uw(OP_NONE,   A_FLO, 1'b1, 2'd0, 2'd0, 1'b1, ACC_HOLD,   1'b0, '0);
			5'd8:  w = uw(OP_NONE,   A_FHI, 1'b1, 2'd0, 2'd0, 1'b1, ACC_LOAD,   1'b0, '0);
			5'd9:  w = uw(OP_NONE,   A_MAG, 1'b0, 2'd0, 2'd0, 1'b0, ACC_ADD_HI, 1'b0, '0);
			5'd10: w = uw(OP_SCALC,  A_MAG, 1'b0, 2'd0, 2'd0, 1'b0, ACC_HOLD,   1'b0, '0);
			5'd11: w = uw(OP_NONE,   A_SLO, 1'b0, 2'd0, 2'd0, 1'b1, ACC_HOLD,   1'b0, '0);
			5'd12: w = uw(OP_NONE,   A_SHI, 1'b0, 2'd0, 2'd0, 1'b1, ACC_LOAD,   1'b0, '0);
			5'd13: w = uw(OP_NONE,   A_MAG, 1'b0, 2'd0, 2'd0, 1'b0, ACC_ADD_HI, 1'b0, '0);
			5'd14: w = uw(OP_NUDGE,  A_SLO, 1'b0, 2'd1, 2'd0, 1'b1, ACC_HOLD,   1'b0, '0);
			5'd15: w = uw(OP_NONE,   A_SHI, 1'b0, 2'd1, 2'd0, 1'b1, ACC_LOAD,   1'b0, '0);
			5'd16: w = uw(OP_NONE,   A_MAG, 1'b0, 2'd0, 2'd0, 1'b0, ACC_ADD_HI, 1'b0, '0);
			5'd17: w = uw(OP_NUDGE,  A_SLO, 1'b0, 2'd2, 2'd1, 1'b1, ACC_HOLD,   1'b0, '0);
			5'd18: w = uw(OP_NONE,   A_SHI, 1'b0, 2'd2, 2'd0, 1'b1, ACC_LOAD,   1'b0, '0);
			5'd19: w = uw(OP_NONE,   A_MAG, 1'b0, 2'd0, 2'd0, 1'b0, ACC_ADD_HI, 1'b0, '0);
			5'd20: w = uw(OP_NUDGE,  A_SLO, 1'b0, 2'd3, 2'd2, 1'b1, ACC_HOLD,   1'b0, '0);
			5'd21: w = uw(OP_NONE,   A_SHI, 1'b0, 2'd3, 2'd0, 1'b1, ACC_LOAD,   1'b0, '0);
			5'd22: w = uw(OP_NONE,   A_MAG, 1'b0, 2'd0, 2'd0, 1'b0, ACC_ADD_HI, 1'b0, '0);
			5'd23: w = uw(OP_NUDGE,  A_MAG, 1'b0, 2'd0, 2'd3, 1'b0, ACC_HOLD,   1'b0, '0);
			default: w = uw(OP_FIN,  A_MAG, 1'b0, 2'd0, 2'd0, 1'b0, ACC_HOLD,   1'b0, '0);
		endcase
		return w;
	endfunction

endpackage

// File: hdl/magnetometer_decode_sphere_calibration_core.sv
// top level: magnetometer decode with hard-iron sphere-fit calibration
// Takes one transaction of six raw magnetometer bytes and a command at a time and
// returns one result transaction for each. A decode-only or calibration-reset command
// runs only the decode, magnitude and finish steps, while a calibrate command runs the
// full 25-step microcode program. Its length is set by the single 32x32 multiplier
// that the program steps through the three squares, the radius square, the gain product
// and four center/radius deltas. The core takes no new item while it is busy with one.
// The result sits in an output register, so the core takes the next item while
// a result is still waiting; it only waits at its last step when the previous result
// has not been taken. Configuration writes are expected only while the core is idle.
module magnetometer_decode_sphere_calibration_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [62:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic [7:0]         x_low_byte,
	input  logic [7:0]         x_high_byte,
	input  logic [7:0]         y_low_byte,
	input  logic [7:0]         y_high_byte,
	input  logic [7:0]         z_low_byte,
	input  logic [7:0]         z_high_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] corrected_x,
	output logic signed [31:0] corrected_y,
	output logic signed [31:0] corrected_z,
	output logic signed [63:0] fit_error,
	output logic               data_nonzero,
	output logic               calibration_was_reset
);
	import mdsc_pkg::*;

	logic [31:0] step_gain_q;
	logic [30:0] start_radius_q;
	logic [62:0] divergence_limit_q;

	logic    busy;
	logic    start;
	logic    calibrate;
	logic    slot_free;
	logic    out_valid_q;
	ctrl_t   ctrl;
	result_t res;
	result_t res_q;

	assign start     = in_valid && !busy;
	assign in_stall  = busy;
	assign slot_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_gain_q        <= STEP_GAIN_RST;
			start_radius_q     <= START_RADIUS_RST;
			divergence_limit_q <= DIVERGENCE_LIMIT_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_STEP_GAIN:        step_gain_q        <= cfg_data[31:0];
				REG_START_RADIUS:     start_radius_q     <= cfg_data[30:0];
				REG_DIVERGENCE_LIMIT: divergence_limit_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	mdsc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.calibrate (calibrate),
		.slot_free (slot_free),
		.busy      (busy),
		.ctrl      (ctrl)
	);

	mdsc_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctrl             (ctrl),
		.cmd              (cmd),
		.x_low_byte       (x_low_byte),
		.x_high_byte      (x_high_byte),
		.y_low_byte       (y_low_byte),
		.y_high_byte      (y_high_byte),
		.z_low_byte       (z_low_byte),
		.z_high_byte      (z_high_byte),
		.step_gain        (step_gain_q),
		.start_radius     (start_radius_q),
		.divergence_limit (divergence_limit_q),
		.calibrate        (calibrate),
		.res              (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.go && (ctrl.uc.op == OP_FIN)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.go && (ctrl.uc.op == OP_FIN)) begin
			res_q <= res;
		end
	end

	assign out_valid             = out_valid_q;
	assign corrected_x           = res_q.corrected_x;
	assign corrected_y           = res_q.corrected_y;
	assign corrected_z           = res_q.corrected_z;
	assign fit_error             = res_q.fit_error;
	assign data_nonzero          = res_q.data_nonzero;
	assign calibration_was_reset = res_q.calibration_was_reset;

endmodule

// File: hdl/mdsc_seq.sv
// microcode sequencer: step counter, program lookup and conditional jump
module mdsc_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           calibrate,
	input  logic           slot_free,
	output logic           busy,
	output mdsc_pkg::ctrl_t ctrl
);
	import mdsc_pkg::*;

	logic   busy_q;
	step_t  step_q;
	ucode_t uc;
	logic   hold;
	logic   go;

	always_comb begin
		uc   = ucode(step_q);
		hold = (uc.op == OP_FIN) && !slot_free;
		go   = busy_q && !hold;
	end

	assign busy       = busy_q;
	assign ctrl.go    = go;
	assign ctrl.start = start;
	assign ctrl.uc    = uc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (!busy_q) begin
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end
		end else if (go) begin
			priority if (uc.op == OP_FIN) begin
				busy_q <= 1'b0;
			end else if (uc.jump && !calibrate) begin
				step_q <= uc.target;
			end else begin
				step_q <= step_q + step_t'(1);
			end
		end
	end

endmodule

// File: hdl/mdsc_dp.sv
// datapath: decode, shared multiplier, accumulator, error and center/radius update
module mdsc_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  mdsc_pkg::ctrl_t     ctrl,
	input  logic [1:0]          cmd,
	input  logic [7:0]          x_low_byte,
	input  logic [7:0]          x_high_byte,
	input  logic [7:0]          y_low_byte,
	input  logic [7:0]          y_high_byte,
	input  logic [7:0]          z_low_byte,
	input  logic [7:0]          z_high_byte,
	input  logic [31:0]         step_gain,
	input  logic [30:0]         start_radius,
	input  logic [62:0]         divergence_limit,
	output logic                calibrate,
	output mdsc_pkg::result_t   res
);
	import mdsc_pkg::*;

	cmd_t               cmd_q;
	logic signed [12:0] rx_q;
	logic signed [12:0] ry_q;
	logic signed [14:0] rz_q;
	logic               nz_q;

	logic signed [31:0] m_q [3];
	logic        [31:0] mag_q [4];
	logic               neg_q [4];
	logic        [63:0] p_q;
	logic        [95:0] acc_q;
	logic signed [63:0] f_q;
	logic        [62:0] fmag_q;
	logic               fneg_q;
	logic        [62:0] s_q;
	logic signed [31:0] cal_q [4];

	logic signed [26:0] scaled [3];
	logic signed [31:0] m_new [3];
	logic        [31:0] a_op;
	logic        [31:0] b_op;
	logic        [63:0] prod;
	logic        [63:0] sq;
	logic        [63:0] dpos;
	logic        [63:0] dneg;
	logic               ge;
	logic        [33:0] nd_mag;
	logic               nd_neg;
	logic signed [35:0] nd_old;
	logic signed [35:0] nd_delta;
	logic signed [35:0] nd_sum;
	logic               fin_reset;

	always_comb begin
		scaled[0] = 27'($signed({rx_q, 12'd0}));
		scaled[1] = 27'($signed({ry_q, 12'd0}));
		scaled[2] = $signed({rz_q, 12'd0});
		for (int i = 0; i < 3; i++) begin
			m_new[i] = sat32(36'(scaled[i]) - 36'(cal_q[i]));
		end

		unique case (ctrl.uc.a_sel)
			A_MAG:   a_op = mag_q[ctrl.uc.m_idx];
			A_FLO:   a_op = fmag_q[31:0];
			A_FHI:   a_op = {1'b0, fmag_q[62:32]};
			A_SLO:   a_op = s_q[31:0];
			A_SHI:   a_op = {1'b0, s_q[62:32]};
			default: a_op = '0;
		endcase
		b_op = ctrl.uc.b_gain ? step_gain : mag_q[ctrl.uc.m_idx];
		prod = 64'(a_op) * 64'(b_op);

		sq   = acc_q[63:0];
		dpos = sq - p_q;
		dneg = p_q - sq;
		ge   = (sq >= p_q);

		nd_mag   = (acc_q[95:65] != '0) ? DELTA_CAP : {1'b0, acc_q[64:32]};
		nd_neg   = fneg_q ^ neg_q[ctrl.uc.n_idx];
		nd_old   = 36'(cal_q[ctrl.uc.n_idx]);
		nd_delta = $signed(36'(nd_mag));
		nd_sum   = nd_neg ? (nd_old - nd_delta) : (nd_old + nd_delta);

		fin_reset = (cmd_q == CMD_RESET)
			|| ((cmd_q == CMD_CALIBRATE) && (f_q > $signed({1'b0, divergence_limit})));
	end

	assign calibrate = (cmd_q == CMD_CALIBRATE);

	assign res.corrected_x           = m_q[0];
	assign res.corrected_y           = m_q[1];
	assign res.corrected_z           = m_q[2];
	assign res.fit_error             = f_q;
	assign res.data_nonzero          = nz_q;
	assign res.calibration_was_reset = fin_reset;

	// calibration state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q[0] <= '0;
			cal_q[1] <= '0;
			cal_q[2] <= '0;
			cal_q[3] <= $signed({1'b0, START_RADIUS_RST});
		end else if (ctrl.go) begin
			if (ctrl.uc.op == OP_NUDGE) begin
				cal_q[ctrl.uc.n_idx] <= sat32(nd_sum);
			end else if ((ctrl.uc.op == OP_FIN) && fin_reset) begin
				cal_q[0] <= '0;
				cal_q[1] <= '0;
				cal_q[2] <= '0;
				cal_q[3] <= $signed({1'b0, start_radius});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			cmd_q <= cmd;
			rx_q  <= $signed({x_high_byte, x_low_byte[7:3]});
			ry_q  <= $signed({y_high_byte, y_low_byte[7:3]});
			rz_q  <= $signed({z_high_byte, z_low_byte[7:1]});
			nz_q  <= (x_low_byte != '0) || (x_high_byte != '0) || (y_low_byte != '0)
				|| (y_high_byte != '0) || (z_low_byte != '0) || (z_high_byte != '0);
		end
		if (ctrl.go) begin
			if (ctrl.uc.mul_en) begin
				p_q <= prod;
			end
			unique case (ctrl.uc.acc)
				ACC_HOLD:   acc_q <= acc_q;
				ACC_LOAD:   acc_q <= 96'(p_q);
				ACC_ADD:    acc_q <= acc_q + 96'(p_q);
				ACC_ADD_HI: acc_q <= acc_q + {p_q, 32'd0};
				default:    acc_q <= acc_q;
			endcase
			unique case (ctrl.uc.op)
				OP_DEC: begin
					for (int i = 0; i < 3; i++) begin
						m_q[i] <= m_new[i];
					end
					f_q <= '0;
				end
				OP_MAG: begin
					for (int i = 0; i < 3; i++) begin
						mag_q[i] <= mag32(m_q[i]);
						neg_q[i] <= m_q[i][31];
					end
					mag_q[3] <= mag32(cal_q[3]);
					neg_q[3] <= cal_q[3][31];
				end
				OP_FCALC: begin
					f_q    <= (ge && dpos[63]) ? 64'sh7FFF_FFFF_FFFF_FFFF : $signed(dpos);
					fmag_q <= ge ? (dpos[63] ? '1 : dpos[62:0]) : dneg[62:0];
					fneg_q <= !ge;
				end
				OP_SCALC: begin
					s_q <= (acc_q[95:93] != '0) ? '1 : acc_q[92:30];
				end
				OP_NONE, OP_NUDGE, OP_FIN: begin
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: hdl/mdsc_checker.sv
// port-level checker for the magnetometer calibration core, with its bind
module mdsc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] corrected_x,
	input logic signed [31:0] corrected_y,
	input logic signed [31:0] corrected_z,
	input logic signed [63:0] fit_error,
	input logic               data_nonzero,
	input logic               calibration_was_reset
);

	// an accepted transaction keeps the core busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("core not busy after accepted transaction");

	// a new result appears only when the core finishes an item
	a_result_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $fell(in_stall))
		else $error("result appeared without an item finishing");

	a_out_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(corrected_x) && $stable(corrected_y)
			&& $stable(corrected_z) && $stable(fit_error) && $stable(data_nonzero)
			&& $stable(calibration_was_reset))
		else $error("result changed while stalled");

endmodule

bind magnetometer_decode_sphere_calibration_core mdsc_checker u_mdsc_checker (.*);
